[hw/rtl/vedge_pkg.sv]
// Shared constants and types for the vertical edge 3x3 convolution unit.
package vedge_pkg;

	localparam int MAX_WIDTH_DEF = 2048;

	// Configuration register indexes
	localparam logic [7:0] REG_IMAGE_WIDTH  = 8'd0;
	localparam logic [7:0] REG_IMAGE_HEIGHT = 8'd1;

	localparam logic [11:0] WIDTH_RESET  = 12'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;
	localparam int          MIN_DIM      = 3;

	// Window centre position and result flags for one pixel
	typedef struct packed {
		logic [10:0] center_col;
		logic [15:0] center_row;
		logic        produce;
		logic        frame_last;
	} pos_t;

endpackage

[hw/rtl/vedge_ctrl.sv]
// Configuration registers and raster column/row counters.
module vedge_ctrl import vedge_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_write,
	input  logic [7:0]    cfg_index,
	input  logic [15:0]   cfg_data,
	input  logic          accept,
	output logic [CW-1:0] addr,
	output pos_t          pos
);

	localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;

	logic [11:0]   image_width_q;
	logic [15:0]   image_height_q;
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;

	logic [WW-1:0] w_eff;
	logic [15:0]   h_eff;
	logic [WW-1:0] col_ext;
	logic          col_wrap;
	logic [WW-1:0] c;
	logic [16:0]   r_pre;
	logic [15:0]   r;
	logic [WW-1:0] c_next;
	logic [16:0]   r_next;
	logic [WW-1:0] c_less;

	// Store configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[11:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp frame dimensions
	always_comb begin
		if (WW'(image_width_q) < WW'(MIN_DIM))
			w_eff = WW'(MIN_DIM);
		else if (WW'(image_width_q) > WW'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(image_width_q);
		h_eff = (image_height_q < 16'(MIN_DIM)) ? 16'(MIN_DIM) : image_height_q;
	end

	// Position of the incoming pixel, ending a row or frame early if shrunk
	always_comb begin
		col_ext  = WW'(col_q);
		col_wrap = (col_ext >= w_eff);
		c        = col_wrap ? '0 : col_ext;
		r_pre    = col_wrap ? ({1'b0, row_q} + 17'd1) : {1'b0, row_q};
		r        = (r_pre >= {1'b0, h_eff}) ? 16'd0 : r_pre[15:0];
		c_less   = c - WW'(1);

		addr           = c[CW-1:0];
		pos.center_col = c_less[10:0];
		pos.center_row = r - 16'd1;
		pos.produce    = (c >= WW'(2)) && (r >= 16'd2);
		pos.frame_last = (c == w_eff - WW'(1)) && (r == h_eff - 16'd1);

		c_next = c + WW'(1);
		r_next = {1'b0, r} + 17'd1;
	end

	// Advance counters on each pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_next >= w_eff) begin
				col_q <= '0;
				row_q <= (r_next >= {1'b0, h_eff}) ? 16'd0 : r_next[15:0];
			end else begin
				col_q <= c_next[CW-1:0];
				row_q <= r;
			end
		end
	end

endmodule

[hw/rtl/vedge_line_buf.sv]
// Two line stores holding the previous two rows of the frame.
module vedge_line_buf import vedge_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [CW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  logic [7:0]    wr_pixel,
	output logic [7:0]    up1_s1,
	output logic [7:0]    up2_s1
);

	logic [7:0] row1_mem [MAX_WIDTH];
	logic [7:0] row2_mem [MAX_WIDTH];

	// Read both rows at the column of the incoming pixel
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up1_s1 <= row1_mem[rd_addr];
			up2_s1 <= row2_mem[rd_addr];
		end
	end

	// Push the column down one row as the pixel retires
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row1_mem[wr_addr] <= wr_pixel;
			row2_mem[wr_addr] <= up1_s1;
		end
	end

endmodule

[hw/rtl/vedge_grad.sv]
// 3x3 window, gradient arithmetic and result output register.
module vedge_grad import vedge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift_en,
	input  logic [7:0]  pixel,
	input  logic [7:0]  up1,
	input  logic [7:0]  up2,
	input  pos_t        pos,
	output logic        load_ok,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	logic [7:0] win_mid_q [3];
	logic [7:0] win_new_q [3];

	logic [9:0]         left_sum;
	logic [9:0]         right_sum;
	logic signed [10:0] grad;

	logic [10:0] gradient_q;
	logic [10:0] center_col_q;
	logic [15:0] center_row_q;

	// Left column is the middle column before the shift, right is the new one
	always_comb begin
		left_sum  = 10'(win_mid_q[0]) + 10'(win_mid_q[1]) + 10'(win_mid_q[2]);
		right_sum = 10'(up2) + 10'(up1) + 10'(pixel);
		grad      = $signed(11'(left_sum)) - $signed(11'(right_sum));
	end

	// Shift the window one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_mid_q[i] <= '0;
				win_new_q[i] <= '0;
			end
		end else if (shift_en) begin
			for (int i = 0; i < 3; i++)
				win_mid_q[i] <= win_new_q[i];
			win_new_q[0] <= up2;
			win_new_q[1] <= up1;
			win_new_q[2] <= pixel;
		end
	end

	assign load_ok = !m_tvalid || m_tready;

	// Hold the result until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (shift_en && pos.produce) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en && pos.produce) begin
			gradient_q   <= grad;
			center_col_q <= pos.center_col;
			center_row_q <= pos.center_row;
			m_tlast      <= pos.frame_last;
		end
	end

	assign m_tdata = {2'b00, center_row_q, center_col_q, gradient_q};

endmodule

[hw/rtl/vertical_edge_conv3x3_unit.sv]
// Streaming 3x3 horizontal gradient (left column minus right column) filter.
//
// Pixels enter on the s_* stream, one 8-bit grayscale sample per transfer in
// raster order. Results leave on the m_* stream, one per interior pixel only:
// border pixels give no result. m_tlast marks the final result of a frame.
// Frame size comes from the cfg_* write channel (index 0: width, index 1:
// height), written while the stream is idle; cfg_ready is always high.
//
// Throughput: one pixel per cycle while the output is not stalled. Each result
// passes through the line store read stage and then the output register.
// The line store is a single-ported read plus single write per cycle memory
// per row, which sets the one-pixel-per-cycle figure.
// When m_tready is low the result holds; one more pixel is taken into the
// read stage, then s_tready drops until the result is transferred. Pixels
// that give no result keep flowing while the output stalls if the read stage
// has room.
// Reset clears the counters, window and valid flags and restores the default
// 640x480 frame size; line stores need no clearing.
module vertical_edge_conv3x3_unit import vedge_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [10:0] gradient, [21:11] center_col, [37:22] center_row
	output logic        m_tlast,   // frame_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          s_accept;
	logic [CW-1:0] addr;
	pos_t          pos;

	logic          valid_s1;
	pos_t          pos_s1;
	logic [7:0]    pixel_s1;
	logic [CW-1:0] addr_s1;
	logic [7:0]    up1_s1;
	logic [7:0]    up2_s1;

	logic          load_ok;
	logic          retire;

	assign cfg_ready = 1'b1;
	assign s_accept  = s_tvalid && s_tready;

	vedge_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (s_accept),
		.addr      (addr),
		.pos       (pos)
	);

	vedge_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
		.clk      (clk),
		.rd_en    (s_accept),
		.rd_addr  (addr),
		.wr_en    (retire),
		.wr_addr  (addr_s1),
		.wr_pixel (pixel_s1),
		.up1_s1   (up1_s1),
		.up2_s1   (up2_s1)
	);

	// Retire the read stage when its result has room, or it has none
	assign retire   = valid_s1 && (!pos_s1.produce || load_ok);
	assign s_tready = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			pos_s1   <= pos;
			pixel_s1 <= s_tdata;
			addr_s1  <= addr;
		end
	end

	vedge_grad u_grad (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (retire),
		.pixel    (pixel_s1),
		.up1      (up1_s1),
		.up2      (up2_s1),
		.pos      (pos_s1),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the streaming 3x3 horizontal gradient unit.
`timescale 1ns / 1ps

module tb;
	import vedge_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int          DRAIN_CYCLES = 4;
	localparam int          RANDOM_PIXELS = 430;
	// Register indexes that the block must ignore
	localparam logic [7:0]  REG_UNUSED_LO = 8'd2;
	localparam logic [7:0]  REG_UNUSED_HI = 8'hFF;

	typedef struct {
		logic signed [10:0] gradient;
		logic [10:0]        center_col;
		logic [15:0]        center_row;
		logic               frame_last;
	} grad_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = 8'd0;
	logic [15:0] cfg_data = 16'd0;

	// Gradient predictor state, mirrors the block after reset
	logic [7:0]  row_above [MAX_WIDTH_DEF];
	logic [7:0]  row_above2 [MAX_WIDTH_DEF];
	logic [7:0]  win [3][3] = '{default: 8'd0};
	int          col_pos = 0;
	int          row_pos = 0;
	logic [11:0] width_reg = WIDTH_RESET;
	logic [15:0] height_reg = HEIGHT_RESET;

	grad_result_t expected_grads [$];
	int           mismatches = 0;
	int           pixels_sent = 0;
	bit           calm = 1'b0;
	int           stall_left = 0;
	int unsigned  cycle_count = 0;

	vertical_edge_conv3x3_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_grads.size());
			$display("vertical_edge_conv3x3_unit: mismatch");
			$finish;
		end
	end

	function automatic int eff_width(input logic [11:0] w);
		if (w < MIN_DIM)
			return MIN_DIM;
		if (w > MAX_WIDTH_DEF)
			return MAX_WIDTH_DEF;
		return int'(w);
	endfunction

	function automatic int eff_height(input logic [15:0] h);
		return (h < MIN_DIM) ? MIN_DIM : int'(h);
	endfunction

	// True when the next pixel lands on row 0, column 0
	function automatic bit at_frame_start();
		int c;
		int r;
		c = col_pos;
		r = row_pos;
		if (c >= eff_width(width_reg)) begin
			c = 0;
			r++;
		end
		if (r >= eff_height(height_reg))
			r = 0;
		return (c == 0) && (r == 0);
	endfunction

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly no gap, sometimes short, rarely long
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the predictor by one pixel and queue any gradient it yields
	task automatic predict_gradient(input logic [7:0] p);
		int w;
		int h;
		int c;
		int r;
		int left;
		int right;
		logic [7:0] up1;
		logic [7:0] up2;
		grad_result_t res;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		c = col_pos;
		r = row_pos;

		up1 = row_above[c];
		up2 = row_above2[c];
		row_above2[c] = up1;
		row_above[c] = p;

		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = up2;
		win[1][2] = up1;
		win[2][2] = p;

		if (c >= 2 && r >= 2) begin
			left = int'(win[0][0]) + int'(win[1][0]) + int'(win[2][0]);
			right = int'(win[0][2]) + int'(win[1][2]) + int'(win[2][2]);
			res.gradient = 11'(left - right);
			res.center_col = 11'(c - 1);
			res.center_row = 16'(r - 1);
			res.frame_last = (c == w - 1) && (r == h - 1);
			expected_grads.push_back(res);
		end

		col_pos = c + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos = r + 1;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	// Send one pixel; valid stays high afterwards unless the next call idles
	task automatic send_pixel(input logic [7:0] p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= p;
		do @(posedge clk); while (!s_tready);
		predict_gradient(p);
		pixels_sent++;
	endtask

	// Hold the input until every expected gradient has come out, then let the pipe empty
	task automatic settle_outputs();
		s_tvalid <= 1'b0;
		while (expected_grads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register transfer, then the channel is left idle before the task returns
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			width_reg = value[11:0];
		else if (idx == REG_IMAGE_HEIGHT)
			height_reg = value;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [15:0] w, input logic [15:0] h);
		settle_outputs();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	task automatic send_pixels(input int n);
		repeat (n) send_pixel(rand_pixel());
	endtask

	task automatic finish_frame();
		while (!at_frame_start())
			send_pixel(rand_pixel());
	endtask

	// Send one whole frame, with a rare full stop of the input
	task automatic send_frame();
		do begin
			if ($urandom_range(0, 149) == 0)
				settle_outputs();
			send_pixel(rand_pixel());
		end while (!at_frame_start());
	endtask

	// Left column full scale against right column zero and the reverse
	task automatic test_gradient_extremes();
		set_frame(16'd3, 16'd3);
		repeat (3) begin
			send_pixel(8'hFF);
			send_pixel(rand_pixel());
			send_pixel(8'h00);
		end
		repeat (3) begin
			send_pixel(8'h00);
			send_pixel(rand_pixel());
			send_pixel(8'hFF);
		end
	endtask

	// Sizes below the minimum act as 3; width keeps only its low 12 bits
	task automatic test_size_clamps();
		set_frame(16'd0, 16'd0);
		send_frame();
		set_frame(16'd1, 16'd2);
		send_frame();
		set_frame(16'd2, 16'd1);
		send_frame();
		set_frame(16'hF005, 16'd3);
		send_frame();
	endtask

	task automatic test_ignored_indexes();
		set_frame(16'd4, 16'd3);
		write_reg(REG_UNUSED_LO, 16'hFFFF);
		write_reg(REG_UNUSED_HI, 16'h0000);
		send_frame();
	endtask

	// Shrink the width while a row is half done: the row ends at once
	task automatic test_width_cut_mid_row();
		set_frame(16'd10, 16'd5);
		send_pixels(27);
		settle_outputs();
		write_reg(REG_IMAGE_WIDTH, 16'd4);
		finish_frame();
	endtask

	// Shrink the height below the current row: the next pixel opens a new frame
	task automatic test_height_cut_mid_frame();
		set_frame(16'd6, 16'd10);
		send_pixels(26);
		settle_outputs();
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		finish_frame();
	endtask

	// Tallest height setting, a few rows, then cut back to a short frame
	task automatic test_tallest_setting();
		set_frame(16'd3, 16'hFFFF);
		send_pixels(18);
		settle_outputs();
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		finish_frame();
	endtask

	task automatic test_random_frames();
		int start_count;
		int w_eff;
		int h_eff;
		logic [15:0] new_w;
		logic [15:0] new_h;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			calm = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) < 7) begin
				case ($urandom_range(0, 19))
					0: new_w = 16'($urandom_range(0, 2));
					1: new_w = 16'($urandom_range(17, 64));
					2: new_w = {4'($urandom), 12'($urandom_range(3, 16))};
					default: new_w = 16'($urandom_range(3, 16));
				endcase
				case ($urandom_range(0, 9))
					0: new_h = 16'($urandom_range(0, 2));
					1: new_h = 16'($urandom_range(9, 20));
					default: new_h = 16'($urandom_range(3, 8));
				endcase
				// Widen only at a frame start so every line store read was written
				if (eff_width(new_w[11:0]) > eff_width(width_reg) && !at_frame_start())
					finish_frame();
				set_frame(new_w, new_h);
			end
			w_eff = eff_width(width_reg);
			h_eff = eff_height(height_reg);
			if ($urandom_range(0, 99) < 80) begin
				send_frame();
			end else begin
				send_pixels($urandom_range(1, w_eff * h_eff - 1));
				settle_outputs();
				if ($urandom_range(0, 1) == 1 && w_eff > MIN_DIM)
					write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(MIN_DIM, w_eff - 1)));
				else
					write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(0, h_eff - 1)));
			end
		end
		calm = 1'b0;
	endtask

	// Output side stalls: mostly ready, short stalls, a few long ones
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) :
				$urandom_range(7, 39);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest expected gradient
	always @(posedge clk) begin : result_check
		grad_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_grads.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: grad %0d col %0d row %0d last %0b",
						$signed(m_tdata[10:0]), m_tdata[21:11], m_tdata[37:22], m_tlast);
				mismatches++;
			end else begin
				want = expected_grads.pop_front();
				if (m_tdata[10:0] !== want.gradient || m_tdata[21:11] !== want.center_col ||
					m_tdata[37:22] !== want.center_row || m_tlast !== want.frame_last) begin
					if (mismatches < 10)
						$display("exp grad %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
							want.gradient, want.center_col, want.center_row, want.frame_last,
							$signed(m_tdata[10:0]), m_tdata[21:11], m_tdata[37:22], m_tlast);
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gradient_extremes();
		test_size_clamps();
		test_ignored_indexes();
		test_width_cut_mid_row();
		test_height_cut_mid_frame();
		test_tallest_setting();
		test_random_frames();

		settle_outputs();
		repeat (2 * DRAIN_CYCLES) @(posedge clk);
		if (expected_grads.size() != 0)
			mismatches++;
		if (mismatches == 0) begin
			$display("vertical_edge_conv3x3_unit: match");
		end else begin
			$display("vertical_edge_conv3x3_unit: mismatch");
		end
		$finish;
	end

endmodule

[vertical_edge_conv3x3_unit.f]
hw/rtl/vedge_pkg.sv
hw/rtl/vedge_ctrl.sv
hw/rtl/vedge_line_buf.sv
hw/rtl/vedge_grad.sv
hw/rtl/vertical_edge_conv3x3_unit.sv
tb/sv/tb.sv
